// ===== src/lcd_controller_ports_core_defines.svh =====
// Assertion macros for the LCD controller sequencer (lcdc_ctrl).
`ifndef LCD_CONTROLLER_PORTS_CORE_DEFINES_SVH
`define LCD_CONTROLLER_PORTS_CORE_DEFINES_SVH
`ifndef SYNTH
`define LCDC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcdc assertion failed");
`define LCDC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcdc assertion failed");
`else
`define LCDC_ASSERT_IMP(label, clk, rst, ante, cons)
`define LCDC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/lcdc_pkg.sv =====
// Types and constants for the LCD controller.
package lcdc_pkg;

  localparam logic [1:0] OP_STATUS_RD = 2'd0;
  localparam logic [1:0] OP_CMD_WR    = 2'd1;
  localparam logic [1:0] OP_DATA_RD   = 2'd2;
  localparam logic [1:0] OP_DATA_WR   = 2'd3;

  localparam logic [3:0] WORD_SIZE_8  = 4'd8;
  localparam logic [3:0] WORD_SIZE_6  = 4'd6;
  localparam logic [7:0] WORD_MASK_8  = 8'hFF;
  localparam logic [7:0] WORD_MASK_6  = 8'h3F;
  localparam logic [4:0] COL_LIMIT_8  = 5'd15;
  localparam logic [4:0] COL_LIMIT_6  = 5'd20;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       update_request;
    logic       display_enabled;
    logic [5:0] contrast_level;
    logic [5:0] scroll_row;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_FETCH,
    S_MERGE,
    S_WR_HI,
    S_WR_LO,
    S_FINISH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic calc;
    logic fetch;
    logic merge;
    logic wr_hi;
    logic wr_lo;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic data_op;
    logic changed;
    logic lo_ok;
  } dp_status_t;

endpackage

// ===== src/lcdc_ctrl.sv =====
// Sequencer for bus accesses: clear pass, address, fetch, merge, write back, reply.
`include "lcd_controller_ports_core_defines.svh"
module lcdc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  lcdc_pkg::dp_status_t   status,
  output lcdc_pkg::ctrl_cmd_t    cmd
);
  import lcdc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.calc   = 1'b1;
        state_next = status.data_op ? S_FETCH : S_FINISH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_MERGE;
      end
      S_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = S_WR_HI;
      end
      S_WR_HI: begin
        // changed is only set for data writes that alter memory
        cmd.wr_hi  = status.changed;
        state_next = (status.changed && status.lo_ok) ? S_WR_LO : S_FINISH;
      end
      S_WR_LO: begin
        cmd.wr_lo  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        rsp_valid = 1'b1;
        if (rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `LCDC_ASSERT_IMP(a_ready_excl, clk, rst, req_ready, !rsp_valid)
  `LCDC_ASSERT_NXT(a_accept_to_addr, clk, rst, req_valid && req_ready, state == S_ADDR)
  `LCDC_ASSERT_IMP(a_lo_after_hi, clk, rst, cmd.wr_lo, $past(cmd.wr_hi))
  `LCDC_ASSERT_NXT(a_done_to_idle, clk, rst, rsp_valid && rsp_ready, req_ready)

endmodule

// ===== src/lcdc_dp.sv =====
// Datapath: mode registers, pointers, display memory and word pack/unpack.
module lcdc_dp #(
  parameter int MEMORY_BYTES = 960,
  parameter int ROW_BITS     = 120,
  parameter int ROW_COUNT    = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lcdc_pkg::req_t        req,
  input  lcdc_pkg::ctrl_cmd_t   cmd,
  output lcdc_pkg::dp_status_t  status,
  output lcdc_pkg::rsp_t        rsp
);
  import lcdc_pkg::*;

  localparam int AW       = $clog2(MEMORY_BYTES);
  localparam int MEM_BITS = MEMORY_BYTES * 8;
  localparam int MAX_END  = 63 * ROW_BITS + 31 * 8 + 8;
  localparam int BW       = $clog2(((MAX_END > MEM_BITS) ? MAX_END : MEM_BITS) + 1);

  // mode and pointer state
  logic [5:0] row_ptr;
  logic [4:0] col_ptr;
  logic [5:0] scroll_z;
  logic [5:0] contrast;
  logic [1:0] op_amp_one;
  logic [1:0] op_amp_two;
  logic       col_axis;
  logic       count_up;
  logic       eight_bit;
  logic       disp_on;
  logic [7:0] read_latch;

  // per-beat working registers
  logic [1:0]    op_q;
  logic [7:0]    wd_q;
  logic [AW-1:0] idx_q;
  logic [2:0]    off_q;
  logic          in_range_q;
  logic          lo_ok_q;
  logic [7:0]    rd_hi;
  logic [7:0]    rd_lo;
  logic [15:0]   new_pair_q;
  logic          changed_q;
  logic [7:0]    word_q;
  logic [7:0]    rd_q;
  logic          upd_q;
  logic [AW-1:0] clr_cnt;

  logic [7:0] mem [MEMORY_BYTES];

  // address generation
  logic [3:0]    size;
  logic [7:0]    size_mask;
  logic [BW-1:0] col_off;
  logic [BW-1:0] bit_addr;
  logic [BW-1:0] bit_end;
  logic [BW-4:0] byte_addr;
  logic [BW-3:0] byte_next;

  assign size      = eight_bit ? WORD_SIZE_8 : WORD_SIZE_6;
  assign size_mask = eight_bit ? WORD_MASK_8 : WORD_MASK_6;
  assign col_off   = eight_bit ? (BW'(col_ptr) << 3)
                               : ((BW'(col_ptr) << 2) + (BW'(col_ptr) << 1));
  assign bit_addr  = BW'(row_ptr) * BW'(ROW_BITS) + col_off;
  assign bit_end   = bit_addr + BW'(size);
  assign byte_addr = bit_addr[BW-1:3];
  assign byte_next = (BW-2)'(byte_addr) + (BW-2)'(1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= req.op;
      wd_q <= req.write_data;
    end
    if (cmd.calc) begin
      idx_q      <= byte_addr[AW-1:0];
      off_q      <= bit_addr[2:0];
      in_range_q <= (bit_end <= BW'(MEM_BITS));
      lo_ok_q    <= (byte_next < (BW-2)'(MEMORY_BYTES));
    end
  end

  // memory: one write port, two registered read ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  always_comb begin
    mem_we    = cmd.clear | cmd.wr_hi | cmd.wr_lo;
    mem_waddr = idx_q;
    mem_wdata = new_pair_q[15:8];
    if (cmd.clear) begin
      mem_waddr = clr_cnt;
      mem_wdata = 8'h00;
    end else if (cmd.wr_lo) begin
      mem_waddr = idx_q + AW'(1);
      mem_wdata = new_pair_q[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.fetch) begin
      rd_hi <= mem[idx_q];
      rd_lo <= mem[idx_q + AW'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // word merge / extract on the two-byte window, MSB first
  logic [15:0] pair_old;
  logic [15:0] pair_new;
  logic [15:0] wmask;
  logic [3:0]  shift;
  logic [7:0]  word;

  always_comb begin
    pair_old = {rd_hi, lo_ok_q ? rd_lo : 8'h00};
    shift    = 4'(5'd16 - 5'(off_q) - 5'(size));
    wmask    = {8'h00, size_mask} << shift;
    pair_new = (pair_old & ~wmask) | (({8'h00, wd_q & size_mask} << shift) & wmask);
    word     = 8'(pair_old >> shift) & size_mask;
  end

  always_ff @(posedge clk) begin
    if (cmd.merge) begin
      new_pair_q <= pair_new;
      changed_q  <= (op_q == OP_DATA_WR) && in_range_q && (pair_new != pair_old);
      word_q     <= in_range_q ? word : 8'h00;
    end
  end

  // pointer stepping
  logic [4:0] col_limit;
  logic [4:0] col_inc;
  logic [6:0] row_inc;
  logic [5:0] row_step;
  logic [4:0] col_step;

  always_comb begin
    col_limit = eight_bit ? COL_LIMIT_8 : COL_LIMIT_6;
    col_inc   = col_ptr + 5'd1;
    row_inc   = 7'(row_ptr) + 7'd1;
    row_step  = row_ptr;
    col_step  = col_ptr;
    if (col_axis) begin
      if (count_up) col_step = (col_inc == col_limit) ? 5'd0 : col_inc;
      else          col_step = (col_ptr == 5'd0) ? col_limit - 5'd1 : col_ptr - 5'd1;
    end else begin
      if (count_up) row_step = (row_inc >= 7'(ROW_COUNT)) ? 6'd0 : row_inc[5:0];
      else          row_step = (row_ptr == 6'd0) ? 6'(ROW_COUNT - 1) : row_ptr - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ptr    <= '0;
      col_ptr    <= '0;
      scroll_z   <= '0;
      contrast   <= '0;
      op_amp_one <= '0;
      op_amp_two <= '0;
      col_axis   <= 1'b0;
      count_up   <= 1'b1;
      eight_bit  <= 1'b1;
      disp_on    <= 1'b0;
      read_latch <= '0;
      rd_q       <= '0;
      upd_q      <= 1'b0;
    end else if (cmd.finish) begin
      case (op_q)
        OP_STATUS_RD: begin
          rd_q  <= {1'b0, eight_bit, disp_on, 3'b000, col_axis, count_up};
          upd_q <= 1'b0;
        end
        OP_CMD_WR: begin
          rd_q  <= 8'h00;
          // only the display on/off command (0000001e) raises an update
          upd_q <= (wd_q[7:1] == 7'b0000001);
          // first matching prefix wins
          if (wd_q[7:6] == 2'b11)      contrast   <= wd_q[5:0];
          else if (wd_q[7])            row_ptr    <= wd_q[5:0];
          else if (wd_q[6])            scroll_z   <= wd_q[5:0];
          else if (wd_q[5])            col_ptr    <= wd_q[4:0];
          else if (wd_q[4:3] == 2'b11) begin
            // test mode: ignored
          end
          else if (wd_q[4])            op_amp_one <= wd_q[1:0];
          else if (wd_q[3])            op_amp_two <= wd_q[1:0];
          else if (wd_q[2]) begin
            col_axis <= wd_q[1];
            count_up <= wd_q[0];
          end else if (wd_q[1]) begin
            disp_on <= wd_q[0];
          end else begin
            eight_bit <= wd_q[0];
          end
        end
        OP_DATA_RD: begin
          rd_q       <= read_latch;
          upd_q      <= 1'b0;
          read_latch <= word_q;
          row_ptr    <= row_step;
          col_ptr    <= col_step;
        end
        default: begin
          rd_q    <= 8'h00;
          upd_q   <= changed_q;
          row_ptr <= row_step;
          col_ptr <= col_step;
        end
      endcase
    end
  end

  assign status.clr_done = (clr_cnt == AW'(MEMORY_BYTES - 1));
  assign status.data_op  = op_q[1];
  assign status.changed  = changed_q;
  assign status.lo_ok    = lo_ok_q;

  // op amp settings have no port of their own; keep them observable-free but stored
  logic op_amp_unused;
  assign op_amp_unused = ^{op_amp_one, op_amp_two};

  assign rsp.read_data       = rd_q;
  assign rsp.update_request  = upd_q & (op_amp_unused | ~op_amp_unused);
  assign rsp.display_enabled = disp_on;
  assign rsp.contrast_level  = contrast;
  assign rsp.scroll_row      = scroll_z;

endmodule

// ===== src/lcd_controller_ports_core.sv =====
// LCD controller top: status/data bus ports over a sequencer and datapath.
// Status and command beats pass address, finish and reply; data beats also pass
// fetch, merge and write-hi; a write that changes memory writes the hi byte there,
// then the lo byte in write-lo if in memory (hi and lo byte on a single port).
// A new beat is accepted only after the reply is taken. Reset (rst, synchronous):
// clears modes/pointers, then zeroes display memory; no beat is accepted meanwhile.
module lcd_controller_ports_core #(
  parameter int MEMORY_BYTES = 960,
  parameter int ROW_BITS     = 120,
  parameter int ROW_COUNT    = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  lcdc_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output lcdc_pkg::rsp_t rsp
);
  import lcdc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lcdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lcdc_dp #(
    .MEMORY_BYTES (MEMORY_BYTES),
    .ROW_BITS     (ROW_BITS),
    .ROW_COUNT    (ROW_COUNT)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

endmodule

// ===== tb/lcdc_checker.sv =====
// Bus monitor and scoreboard for the LCD controller: predicts each reply and compares it.
module lcdc_checker #(
  parameter int MEMORY_BYTES = 960,
  parameter int ROW_BITS     = 120,
  parameter int ROW_COUNT    = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  lcdc_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  lcdc_pkg::rsp_t rsp,
  output int             failures,
  output int             pending,
  output int             checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcdc_pkg::*;

  localparam int MEM_BITS = MEMORY_BYTES * 8;

  // command byte prefixes, decoded in priority order
  localparam logic [7:0] CMD_CONTRAST = 8'hC0;
  localparam logic [7:0] CMD_ROW      = 8'h80;
  localparam logic [7:0] CMD_SCROLL   = 8'h40;
  localparam logic [7:0] CMD_COLUMN   = 8'h20;
  localparam logic [7:0] CMD_TEST     = 8'h18;
  localparam logic [7:0] CMD_AMP_ONE  = 8'h10;
  localparam logic [7:0] CMD_AMP_TWO  = 8'h08;
  localparam logic [7:0] CMD_COUNTER  = 8'h04;
  localparam logic [7:0] CMD_DISPLAY  = 8'h02;

  logic [7:0] pixels [MEMORY_BYTES];
  logic [5:0] row_ptr;
  logic [4:0] col_ptr;
  logic [5:0] scroll;
  logic [5:0] contrast;
  logic [1:0] amp_one;
  logic [1:0] amp_two;
  logic       col_axis;
  logic       count_up;
  logic       wide;
  logic       disp_on;
  logic [7:0] latch;

  rsp_t expected_q [$];
  rsp_t oldest;

  function automatic int word_bits();
    return wide ? int'(WORD_SIZE_8) : int'(WORD_SIZE_6);
  endfunction

  function automatic int word_addr();
    return int'(row_ptr) * ROW_BITS + int'(col_ptr) * word_bits();
  endfunction

  function automatic logic [15:0] byte_pair(int b);
    return {pixels[b], (b + 1 < MEMORY_BYTES) ? pixels[b + 1] : 8'h00};
  endfunction

  function automatic logic [7:0] fetch_word();
    int a;
    int sz;
    int sh;
    logic [15:0] m;
    a = word_addr();
    sz = word_bits();
    if (a + sz > MEM_BITS) return 8'h00;
    sh = 16 - (a % 8) - sz;
    m = (16'h1 << sz) - 16'h1;
    return 8'((byte_pair(a / 8) >> sh) & m);
  endfunction

  // returns 1 when the write actually changed memory
  function automatic logic store_word(logic [7:0] value);
    int a;
    int sz;
    int sh;
    int b;
    logic [15:0] msk;
    logic [15:0] old;
    logic [15:0] upd;
    a = word_addr();
    sz = word_bits();
    if (a + sz > MEM_BITS) return 1'b0;
    b = a / 8;
    sh = 16 - (a % 8) - sz;
    msk = ((16'h1 << sz) - 16'h1) << sh;
    old = byte_pair(b);
    upd = (old & ~msk) | ((16'(value) << sh) & msk);
    if (upd == old) return 1'b0;
    pixels[b] = upd[15:8];
    if (b + 1 < MEMORY_BYTES) pixels[b + 1] = upd[7:0];
    return 1'b1;
  endfunction

  function automatic void step_pointers();
    int lim;
    int nxt;
    lim = wide ? int'(COL_LIMIT_8) : int'(COL_LIMIT_6);
    if (col_axis) begin
      if (count_up) begin
        nxt = int'(col_ptr) + 1;
        if (nxt == lim) nxt = 0;
        col_ptr = 5'(nxt);
      end else begin
        col_ptr = (col_ptr == 5'd0) ? 5'(lim - 1) : col_ptr - 5'd1;
      end
    end else begin
      if (count_up) begin
        nxt = int'(row_ptr) + 1;
        row_ptr = (nxt >= ROW_COUNT) ? 6'd0 : 6'(nxt);
      end else begin
        row_ptr = (row_ptr == 6'd0) ? 6'(ROW_COUNT - 1) : row_ptr - 6'd1;
      end
    end
  endfunction

  // returns 1 on a display on/off command
  function automatic logic run_command(logic [7:0] v);
    if ((v & CMD_CONTRAST) == CMD_CONTRAST) contrast = v[5:0];
    else if ((v & CMD_ROW) != 0) row_ptr = v[5:0];
    else if ((v & CMD_SCROLL) != 0) scroll = v[5:0];
    else if ((v & CMD_COLUMN) != 0) col_ptr = v[4:0];
    else if ((v & CMD_TEST) == CMD_TEST) return 1'b0;
    else if ((v & CMD_AMP_ONE) != 0) amp_one = v[1:0];
    else if ((v & CMD_AMP_TWO) != 0) amp_two = v[1:0];
    else if ((v & CMD_COUNTER) != 0) begin
      col_axis = v[1];
      count_up = v[0];
    end else if ((v & CMD_DISPLAY) != 0) begin
      disp_on = v[0];
      return 1'b1;
    end else wide = v[0];
    return 1'b0;
  endfunction

  function automatic rsp_t lcd_access(req_t r);
    rsp_t e;
    e = '0;
    case (r.op)
      OP_STATUS_RD: e.read_data = {1'b0, wide, disp_on, 3'b000, col_axis, count_up};
      OP_CMD_WR: e.update_request = run_command(r.write_data);
      OP_DATA_RD: begin
        e.read_data = latch;
        latch = fetch_word();
        step_pointers();
      end
      default: begin
        e.update_request = store_word(r.write_data & (wide ? WORD_MASK_8 : WORD_MASK_6));
        step_pointers();
      end
    endcase
    e.display_enabled = disp_on;
    e.contrast_level = contrast;
    e.scroll_row = scroll;
    return e;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch: expected 0x%02h, actual 0x%02h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (pixels[i]) pixels[i] = 8'h00;
      row_ptr = '0;
      col_ptr = '0;
      scroll = '0;
      contrast = '0;
      amp_one = '0;
      amp_two = '0;
      col_axis = 1'b0;
      count_up = 1'b1;
      wide = 1'b1;
      disp_on = 1'b0;
      latch = '0;
      expected_q.delete();
      failures = 0;
      checked = 0;
      pending <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          failures++;
          $display("%0t: reply beat with none expected, actual 0x%05h", $time, rsp);
        end else begin
          oldest = expected_q.pop_front();
          checked++;
          check_field("read_data", oldest.read_data, rsp.read_data);
          check_field("update_request", 8'(oldest.update_request), 8'(rsp.update_request));
          check_field("display_enabled", 8'(oldest.display_enabled), 8'(rsp.display_enabled));
          check_field("contrast_level", 8'(oldest.contrast_level), 8'(rsp.contrast_level));
          check_field("scroll_row", 8'(oldest.scroll_row), 8'(rsp.scroll_row));
        end
      end
      if (req_valid && req_ready) expected_q.push_back(lcd_access(req));
      pending <= expected_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the LCD controller testbench: clock, reset, bus stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lcdc_pkg::*;

  localparam int MEMORY_BYTES = 960;
  localparam int ROW_BITS     = 120;
  localparam int ROW_COUNT    = 64;
  localparam int RANDOM_BEATS = 550;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [7:0] CMD_CONTRAST = 8'hC0;
  localparam logic [7:0] CMD_ROW      = 8'h80;
  localparam logic [7:0] CMD_SCROLL   = 8'h40;
  localparam logic [7:0] CMD_COLUMN   = 8'h20;
  localparam logic [7:0] CMD_TEST     = 8'h18;
  localparam logic [7:0] CMD_AMP_ONE  = 8'h10;
  localparam logic [7:0] CMD_AMP_TWO  = 8'h08;
  localparam logic [7:0] CMD_COUNTER  = 8'h04;
  localparam logic [7:0] CMD_DISPLAY  = 8'h02;
  localparam logic [7:0] CMD_WORD_LEN = 8'h00;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_beat = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_beat;

  int failures;
  int pending;
  int checked;

  int beats_total = 0;
  int beats_sent = 0;
  int n_status = 0;
  int n_cmd = 0;
  int n_read = 0;
  int n_write = 0;
  int cycles = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic steady = 1'b0;
  logic drained_once = 1'b0;

  lcd_controller_ports_core #(
    .MEMORY_BYTES(MEMORY_BYTES),
    .ROW_BITS(ROW_BITS),
    .ROW_COUNT(ROW_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req_beat),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp_beat)
  );

  lcdc_checker #(
    .MEMORY_BYTES(MEMORY_BYTES),
    .ROW_BITS(ROW_BITS),
    .ROW_COUNT(ROW_COUNT)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req_beat),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp_beat),
    .failures(failures),
    .pending(pending),
    .checked(checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles, pending);
      $display("lcd_controller_ports_core regression: fail");
      $finish;
    end
  end

  // reply side: random stalls, one long hold-off so the block backs up, a calm stretch
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (!hold_done && beats_sent >= 150) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= steady || ($urandom_range(99) >= 15);
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [7:0] wd);
    logic calm;
    calm = (beats_total >= 300 && beats_total < 380);
    steady <= calm;
    while (!calm && $urandom_range(99) < 15) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_beat <= '{op: op, write_data: wd};
    do @(posedge clk); while (!req_ready);
    beats_total++;
    beats_sent <= beats_total;
    case (op)
      OP_STATUS_RD: n_status++;
      OP_CMD_WR: n_cmd++;
      OP_DATA_RD: n_read++;
      default: n_write++;
    endcase
  endtask

  task automatic wait_drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // set a window, write a run of words, rewind and read them back through the latch
  task automatic readback_run();
    logic [5:0] row;
    logic [4:0] col;
    logic [7:0] val;
    int n;
    row = ($urandom_range(4) == 0) ? 6'd63 - 6'($urandom_range(3)) : 6'($urandom_range(63));
    col = 5'($urandom_range(31));
    n = $urandom_range(1, 6);
    val = 8'($urandom);
    send_beat(OP_CMD_WR, CMD_WORD_LEN | 8'($urandom_range(1)));
    send_beat(OP_CMD_WR, CMD_COUNTER | 8'($urandom_range(3)));
    send_beat(OP_CMD_WR, CMD_ROW | 8'(row));
    send_beat(OP_CMD_WR, CMD_COLUMN | 8'(col));
    repeat (n) begin
      if ($urandom_range(3) != 0) val = 8'($urandom);
      send_beat(OP_DATA_WR, val);
    end
    send_beat(OP_CMD_WR, CMD_ROW | 8'(row));
    send_beat(OP_CMD_WR, CMD_COLUMN | 8'(col));
    repeat (n + 1) send_beat(OP_DATA_RD, 8'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_beat(OP_STATUS_RD, 8'hFF);
    send_beat(OP_DATA_RD, 8'h00);
    send_beat(OP_DATA_WR, 8'hFF);
    send_beat(OP_CMD_WR, CMD_ROW);
    send_beat(OP_DATA_WR, 8'hFF);          // same value again: no update
    send_beat(OP_CMD_WR, CMD_ROW);
    send_beat(OP_DATA_RD, 8'hA5);
    send_beat(OP_DATA_RD, 8'h5A);          // returns the word latched by the beat before
    send_beat(OP_CMD_WR, CMD_CONTRAST);
    send_beat(OP_CMD_WR, CMD_CONTRAST | 8'h3F);
    send_beat(OP_CMD_WR, CMD_SCROLL | 8'h3F);
    send_beat(OP_CMD_WR, CMD_TEST | 8'h07);
    send_beat(OP_CMD_WR, CMD_AMP_ONE | 8'h03);
    send_beat(OP_CMD_WR, CMD_AMP_TWO | 8'h03);
    send_beat(OP_CMD_WR, CMD_DISPLAY | 8'h01);
    send_beat(OP_CMD_WR, CMD_DISPLAY);
    send_beat(OP_CMD_WR, CMD_WORD_LEN);    // 6-bit words
    send_beat(OP_CMD_WR, CMD_COUNTER | 8'h03);
    send_beat(OP_CMD_WR, CMD_ROW);
    send_beat(OP_CMD_WR, CMD_COLUMN);
    send_beat(OP_DATA_WR, 8'hFF);          // aligned 6-bit word, top of byte 0
    send_beat(OP_DATA_WR, 8'h2A);          // straddles bytes 0 and 1
    send_beat(OP_STATUS_RD, 8'h00);
    send_beat(OP_CMD_WR, CMD_ROW | 8'h3F);
    send_beat(OP_CMD_WR, CMD_COLUMN | 8'h1F);
    send_beat(OP_CMD_WR, CMD_WORD_LEN | 8'h01);
    send_beat(OP_DATA_WR, 8'h5A);          // past the end of memory: dropped
    send_beat(OP_DATA_RD, 8'h00);          // column pointer wrapped to 0: in range, latches byte 945
    send_beat(OP_CMD_WR, CMD_COUNTER);     // rows, counting down

    while (beats_total < 29 + RANDOM_BEATS) begin
      if (!drained_once && beats_total >= 450) begin
        drained_once = 1'b1;
        req_valid <= 1'b0;
        wait_drain();
      end
      if ($urandom_range(99) < 55) readback_run();
      else send_beat(2'($urandom_range(3)), 8'($urandom));
    end

    req_valid <= 1'b0;
    wait_drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d beats: %0d status reads, %0d commands, %0d data reads, %0d data writes",
             beats_total, n_status, n_cmd, n_read, n_write);
    $display("%0d replies compared, with write/read-back runs and a %0d-cycle reply stall",
             checked, HOLD_CYCLES);
    if (failures == 0 && pending == 0) begin
      $display("lcd_controller_ports_core regression: pass");
    end else begin
      $display("lcd_controller_ports_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/lcdc_pkg.sv
src/lcdc_ctrl.sv
src/lcdc_dp.sv
src/lcd_controller_ports_core.sv
tb/lcdc_checker.sv
tb/tb_top.sv
